FILE: rtl/core/exrm_pkg.sv
// ----------------------------------------------------------------------------
// exrm_pkg
// types, constants and tables shared by the euler angle to rotation matrix core
// ----------------------------------------------------------------------------
package exrm_pkg;

   localparam int ANGLE_W  = 17;
   localparam int POS_W    = 32;
   localparam int ELEM_W   = 16;
   localparam int CW       = 34;
   localparam int ZW       = 20;
   localparam int TABLE_LEN = 32;

   localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [ZW-1:0] PI_Q16      = 20'sd205887;
   localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;

   typedef logic signed [CW-1:0] cval_type;
   typedef logic signed [ZW-1:0] zval_type;

   typedef struct packed {
      cval_type x;
      cval_type y;
      zval_type z;
   } cordic_lane_type;

   typedef struct packed {
      cordic_lane_type ax;
      cordic_lane_type ay;
      cordic_lane_type az;
      logic            nx;
      logic            ny;
      logic            nz;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic [POS_W-1:0] pz;
   } cell_data_type;

   function automatic zval_type atan_q16(input logic [4:0] idx);
      zval_type t;
      case (idx)
         5'd0:    t = 20'sd51472;
         5'd1:    t = 20'sd30386;
         5'd2:    t = 20'sd16055;
         5'd3:    t = 20'sd8150;
         5'd4:    t = 20'sd4091;
         5'd5:    t = 20'sd2047;
         5'd6:    t = 20'sd1024;
         5'd7:    t = 20'sd512;
         5'd8:    t = 20'sd256;
         5'd9:    t = 20'sd128;
         5'd10:   t = 20'sd64;
         5'd11:   t = 20'sd32;
         5'd12:   t = 20'sd16;
         5'd13:   t = 20'sd8;
         5'd14:   t = 20'sd4;
         5'd15:   t = 20'sd2;
         5'd16:   t = 20'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/core/exrm_cell.sv
// ----------------------------------------------------------------------------
// exrm_cell
// one cordic micro-rotation for all three angles, registered
// ----------------------------------------------------------------------------
module exrm_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  exrm_pkg::cell_data_type d_in,
   output exrm_pkg::cell_data_type d_out
);

   exrm_pkg::cell_data_type data_ff, data_in;

   function automatic exrm_pkg::cordic_lane_type rot(input exrm_pkg::cordic_lane_type a);
      exrm_pkg::cordic_lane_type r;
      exrm_pkg::zval_type t;
      t = exrm_pkg::atan_q16(5'(STEP));
      if (a.z >= 0) begin
         r.x = a.x - (a.y >>> STEP);
         r.y = a.y + (a.x >>> STEP);
         r.z = a.z - t;
      end else begin
         r.x = a.x + (a.y >>> STEP);
         r.y = a.y - (a.x >>> STEP);
         r.z = a.z + t;
      end
      return r;
   endfunction

   always_comb begin
      data_in    = d_in;
      data_in.ax = rot(d_in.ax);
      data_in.ay = rot(d_in.ay);
      data_in.az = rot(d_in.az);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign d_out = data_ff;

endmodule

FILE: rtl/core/exrm_matrix.sv
// ----------------------------------------------------------------------------
// exrm_matrix
// three-stage product network forming the nine rotation elements
// ----------------------------------------------------------------------------
module exrm_matrix #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic [2:0]              enable,
   input  exrm_pkg::cell_data_type d_in,
   output logic [9*exrm_pkg::ELEM_W-1:0] elems,
   output logic [3*exrm_pkg::POS_W-1:0]  pos
);

   typedef logic signed [exrm_pkg::CW-1:0] v_type;
   localparam int SH = 30 - OUT_FRAC_BITS;

   function automatic v_type fmul(input v_type a, input v_type b);
      logic signed [2*exrm_pkg::CW-1:0] p;
      p = a * b;
      return v_type'(p >>> 30);
   endfunction

   function automatic logic [exrm_pkg::ELEM_W-1:0] to_out(input v_type v);
      logic signed [exrm_pkg::CW:0] r;
      logic signed [exrm_pkg::CW:0] lim;
      lim = (exrm_pkg::CW+1)'(1) <<< OUT_FRAC_BITS;
      r = (exrm_pkg::CW+1)'(v);
      if (SH > 0) begin
         r = (r + ((exrm_pkg::CW+1)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
      end
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[exrm_pkg::ELEM_W-1:0];
   endfunction

   // stage 1: sign fix of the sine and cosine terms
   v_type sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff;
   v_type sycz_ff, sysz_ff, cycz_ff, cysz_ff, sxcy_ff, cxcy_ff, cxcz_ff, sxsz_ff;
   v_type sxcz_ff, cxsz_ff;
   logic [3*exrm_pkg::POS_W-1:0] pos1_ff, pos2_ff, pos3_ff;
   v_type sx_in, cx_in, sy_in, cy_in, sz_in, cz_in;

   always_comb begin
      sx_in = d_in.nx ? -d_in.ax.y : d_in.ax.y;
      cx_in = d_in.nx ? -d_in.ax.x : d_in.ax.x;
      sy_in = d_in.ny ? -d_in.ay.y : d_in.ay.y;
      cy_in = d_in.ny ? -d_in.ay.x : d_in.ay.x;
      sz_in = d_in.nz ? -d_in.az.y : d_in.az.y;
      cz_in = d_in.nz ? -d_in.az.x : d_in.az.x;
   end

   always_ff @(posedge clock) begin
      if (enable[0]) begin
         sx_ff   <= sx_in;
         cx_ff   <= cx_in;
         sy_ff   <= sy_in;
         cy_ff   <= cy_in;
         sz_ff   <= sz_in;
         cz_ff   <= cz_in;
         pos1_ff <= {d_in.pz, d_in.py, d_in.px};
      end
   end

   // stage 2: pairwise products
   always_ff @(posedge clock) begin
      if (enable[1]) begin
         sycz_ff <= fmul(sy_ff, cz_ff);
         sysz_ff <= fmul(sy_ff, sz_ff);
         cycz_ff <= fmul(cy_ff, cz_ff);
         cysz_ff <= fmul(cy_ff, sz_ff);
         sxcy_ff <= fmul(sx_ff, cy_ff);
         cxcy_ff <= fmul(cx_ff, cy_ff);
         cxcz_ff <= fmul(cx_ff, cz_ff);
         sxsz_ff <= fmul(sx_ff, sz_ff);
         sxcz_ff <= fmul(sx_ff, cz_ff);
         cxsz_ff <= fmul(cx_ff, sz_ff);
         pos2_ff <= pos1_ff;
      end
   end

   // keep angle terms aligned with stage 2
   v_type sx2_ff, cx2_ff, sy2_ff;
   always_ff @(posedge clock) begin
      if (enable[1]) begin
         sx2_ff <= sx_ff;
         cx2_ff <= cx_ff;
         sy2_ff <= sy_ff;
      end
   end

   // stage 3: triple products, sums and output rounding
   logic [9*exrm_pkg::ELEM_W-1:0] elems_ff;
   always_ff @(posedge clock) begin
      if (enable[2]) begin
         elems_ff <= {
            to_out(cxcy_ff),
            to_out(fmul(cx2_ff, sysz_ff) + sxcz_ff),
            to_out(sxsz_ff - fmul(cx2_ff, sycz_ff)),
            to_out(-sxcy_ff),
            to_out(cxcz_ff - fmul(sx2_ff, sysz_ff)),
            to_out(fmul(sx2_ff, sycz_ff) + cxsz_ff),
            to_out(sy2_ff),
            to_out(-cysz_ff),
            to_out(cycz_ff)};
         pos3_ff <= pos2_ff;
      end
   end

   assign elems = elems_ff;
   assign pos   = pos3_ff;

endmodule

FILE: rtl/core/euler_xyz_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_xyz_to_rotation_matrix_core
// x-y-z angles to rotation matrix via a chain of cordic cells and products
// ----------------------------------------------------------------------------
// a request passes the entry register, the cordic cell chain and the matrix product stages before rsp valid
// throughput: one item per cycle while not stalled, set by one cordic cell per micro-rotation
// the whole pipeline stalls only when the output register is full and not taken
// reset clears all stage valid bits; payload registers are not reset
module euler_xyz_to_rotation_matrix_core #(
   parameter int CORDIC_STEPS  = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // angle_x, angle_y, angle_z, pos_x, pos_y, pos_z, zero pad
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // m00..m22, out_x, out_y, out_z
   output logic [239:0] rsp_tdata
);

   localparam int NS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
   localparam int NST = NS + 4;

   logic [NST-1:0] vld_ff, vld_in;
   logic           adv;

   // pipeline moves when the last stage is empty or taken
   assign adv        = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NST-1];

   always_comb begin
      vld_in = vld_ff;
      if (adv) vld_in = {vld_ff[NST-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   function automatic exrm_pkg::cordic_lane_type prep(
      input logic [exrm_pkg::ANGLE_W-1:0] a, output logic neg);
      exrm_pkg::cordic_lane_type r;
      exrm_pkg::zval_type z;
      z = exrm_pkg::zval_type'($signed(a)) <<< 2;
      neg = 1'b0;
      if (z > exrm_pkg::HALF_PI_Q16) begin
         z = z - exrm_pkg::PI_Q16;
         neg = 1'b1;
      end else if (z < -exrm_pkg::HALF_PI_Q16) begin
         z = z + exrm_pkg::PI_Q16;
         neg = 1'b1;
      end
      r.x = exrm_pkg::GAIN_Q30;
      r.y = '0;
      r.z = z;
      return r;
   endfunction

   exrm_pkg::cell_data_type entry_in, entry_ff;
   always_comb begin
      entry_in.ax = prep(req_tdata[16:0],  entry_in.nx);
      entry_in.ay = prep(req_tdata[33:17], entry_in.ny);
      entry_in.az = prep(req_tdata[50:34], entry_in.nz);
      entry_in.px = req_tdata[82:51];
      entry_in.py = req_tdata[114:83];
      entry_in.pz = req_tdata[146:115];
   end

   always_ff @(posedge clock) begin
      if (adv) entry_ff <= entry_in;
   end

   exrm_pkg::cell_data_type chain [0:NS];
   assign chain[0] = entry_ff;

   for (genvar i = 0; i < NS; i++) begin : g_cell
      exrm_cell #(.STEP(i)) u_cell (
         .clock  (clock),
         .enable (adv),
         .d_in   (chain[i]),
         .d_out  (chain[i+1])
      );
   end

   logic [9*exrm_pkg::ELEM_W-1:0] elems;
   logic [3*exrm_pkg::POS_W-1:0]  pos;

   exrm_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
      .clock  (clock),
      .enable ({adv, adv, adv}),
      .d_in   (chain[NS]),
      .elems  (elems),
      .pos    (pos)
   );

   assign rsp_tdata = {pos, elems};

endmodule

FILE: rtl/core/exrm_checker.sv
// ----------------------------------------------------------------------------
// exrm_checker
// port-level checks for the rotation matrix core
// ----------------------------------------------------------------------------
module exrm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [239:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   a_ready_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> req_tready)
      else $error("input blocked while output drains");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind euler_xyz_to_rotation_matrix_core exrm_checker u_exrm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
